### hw/rtl/npt_pkg.sv
// shared types, constants and code tables for the nearest-point-on-triangle block
// no dependencies
`default_nettype none

package npt_pkg;

    localparam int COORD_W = 24;
    localparam int FACE_W  = 20;
    localparam int DIST_W  = 52;
    localparam int RATIO_W = 24;
    localparam int Q_W     = RATIO_W + 1;
    localparam int VEC_W   = COORD_W + 1;
    localparam int DOT_W   = 52;
    localparam int HALF_W  = DOT_W / 2;
    localparam int WIDE_W  = 108;
    localparam int OPD_W   = 27;
    localparam int PROD_W  = 2 * OPD_W;
    localparam int IN_W    = 240;
    localparam int OUT_W   = 3 * COORD_W + DIST_W + FACE_W;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

    // operand sources of the shared multiplier
    localparam logic [3:0] SRC_ZERO = 4'd0;
    localparam logic [3:0] SRC_AB   = 4'd1;
    localparam logic [3:0] SRC_AC   = 4'd2;
    localparam logic [3:0] SRC_AP   = 4'd3;
    localparam logic [3:0] SRC_BP   = 4'd4;
    localparam logic [3:0] SRC_CP   = 4'd5;
    localparam logic [3:0] SRC_DLO  = 4'd6;
    localparam logic [3:0] SRC_DHI  = 4'd7;
    localparam logic [3:0] SRC_DIR  = 4'd8;
    localparam logic [3:0] SRC_Q1   = 4'd9;
    localparam logic [3:0] SRC_Q2   = 4'd10;
    localparam logic [3:0] SRC_DIFF = 4'd11;

    // accumulator destinations
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_D0   = 4'd1;
    localparam logic [3:0] DST_D1   = 4'd2;
    localparam logic [3:0] DST_D2   = 4'd3;
    localparam logic [3:0] DST_D3   = 4'd4;
    localparam logic [3:0] DST_D4   = 4'd5;
    localparam logic [3:0] DST_D5   = 4'd6;
    localparam logic [3:0] DST_VA   = 4'd7;
    localparam logic [3:0] DST_VB   = 4'd8;
    localparam logic [3:0] DST_VC   = 4'd9;
    localparam logic [3:0] DST_PT0  = 4'd10;
    localparam logic [3:0] DST_PT1  = 4'd11;
    localparam logic [3:0] DST_PT2  = 4'd12;
    localparam logic [3:0] DST_DIST = 4'd13;

    // product shift codes
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_26 = 2'd1;
    localparam logic [1:0] SH_52 = 2'd2;

    // closest feature of the triangle
    localparam logic [2:0] RG_A  = 3'd0;
    localparam logic [2:0] RG_B  = 3'd1;
    localparam logic [2:0] RG_AB = 3'd2;
    localparam logic [2:0] RG_C  = 3'd3;
    localparam logic [2:0] RG_AC = 3'd4;
    localparam logic [2:0] RG_BC = 3'd5;
    localparam logic [2:0] RG_IN = 3'd6;

    typedef struct packed {
        logic [3:0] src;
        logic [2:0] idx;
    } opnd_t;

    typedef struct packed {
        logic       valid;
        opnd_t      a;
        opnd_t      b;
        logic [1:0] shift;
        logic       neg;
        logic       first;
        logic [3:0] dest;
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        logic    div_start;
        logic    div_sel;
        logic    cap_q1;
        logic    cap_q2;
        logic    upd;
        logic    in_ready;
    } ctl_t;

    // d indexes of the cross terms: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6,
    // va = d3*d6 - d5*d4 (d numbered from 1, stored from 0)
    function automatic logic [2:0] cross_idx(input logic [1:0] j, input logic p,
                                             input logic y);
        logic [2:0] r;
        case ({j, p, y})
            4'b0000: r = 3'd0;
            4'b0001: r = 3'd3;
            4'b0010: r = 3'd2;
            4'b0011: r = 3'd1;
            4'b0100: r = 3'd4;
            4'b0101: r = 3'd1;
            4'b0110: r = 3'd0;
            4'b0111: r = 3'd5;
            4'b1000: r = 3'd2;
            4'b1001: r = 3'd5;
            4'b1010: r = 3'd4;
            4'b1011: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/npt_mac.sv
// shared multiply-accumulate unit: registered 27x27 product, shifted accumulate
// depends on npt_pkg
`default_nettype none

module npt_mac
    import npt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mac_op_t                  op,
    input  wire logic signed [OPD_W-1:0]  opa,
    input  wire logic signed [OPD_W-1:0]  opb,
    output logic signed [WIDE_W-1:0]      acc,
    output logic                          wr,
    output logic [3:0]                    wr_dest
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     t_valid_reg;
    logic [1:0]               t_shift_reg;
    logic                     t_neg_reg;
    logic                     t_first_reg;
    logic [3:0]               t_dest_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] acc_next;
    logic signed [WIDE_W-1:0] ext;
    logic signed [WIDE_W-1:0] term;
    logic                     wr_reg;
    logic [3:0]               wr_dest_reg;

    always_ff @(posedge aclk) begin
        prod_reg    <= opa * opb;
        t_shift_reg <= op.shift;
        t_neg_reg   <= op.neg;
        t_first_reg <= op.first;
        t_dest_reg  <= op.dest;
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else begin
            t_valid_reg <= op.valid;
        end
    end

    always_comb begin
        ext = WIDE_W'(prod_reg);
        case (t_shift_reg)
            SH_26:   term = ext <<< 26;
            SH_52:   term = ext <<< 52;
            default: term = ext;
        endcase
        if (t_neg_reg) begin
            term = -term;
        end
        acc_next = t_first_reg ? term : acc_reg + term;
    end

    always_ff @(posedge aclk) begin
        if (t_valid_reg) begin
            acc_reg <= acc_next;
        end
        wr_dest_reg <= t_dest_reg;
        if (!aresetn) begin
            wr_reg <= 1'b0;
        end else begin
            wr_reg <= t_valid_reg && (t_dest_reg != DST_NONE);
        end
    end

    assign acc     = acc_reg;
    assign wr      = wr_reg;
    assign wr_dest = wr_dest_reg;

endmodule

`default_nettype wire

### hw/rtl/npt_div.sv
// serial restoring divider for the clamped q1.24 ratio, one quotient bit per cycle
// depends on npt_pkg
`default_nettype none

module npt_div
    import npt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [WIDE_W-1:0] num,
    input  wire logic signed [WIDE_W-1:0] den,
    output logic [Q_W-1:0]                q,
    output logic                          done
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] dsr_reg;
    logic [Q_W-1:0]    q_reg;
    logic [WIDE_W:0]   rem2;
    logic [WIDE_W:0]   diff;

    always_comb begin
        rem2 = {rem_reg, 1'b0};
        diff = rem2 - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                if (den <= 0 || num <= 0) begin
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end else if (num >= den) begin
                    q_reg    <= Q_W'(1) << RATIO_W;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                    rem_reg  <= num;
                    dsr_reg  <= den;
                    cnt_reg  <= '0;
                    q_reg    <= '0;
                end
            end else if (busy_reg) begin
                if (!diff[WIDE_W]) begin
                    rem_reg <= diff[WIDE_W-1:0];
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem2[WIDE_W-1:0];
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg + 5'd1;
                done_reg <= (cnt_reg == 5'(RATIO_W - 1));
                if (cnt_reg == 5'(RATIO_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### hw/rtl/npt_seq.sv
// sequencer: issues the multiply schedule, runs the divider, commits the result
// depends on npt_pkg
`default_nettype none

module npt_seq
    import npt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_fire,
    input  wire logic div_done,
    input  wire logic last,
    input  wire logic out_full,
    output ctl_t      ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DOT    = 4'd1;
    localparam logic [3:0] ST_CROSS  = 4'd2;
    localparam logic [3:0] ST_DRAIN1 = 4'd3;
    localparam logic [3:0] ST_DIV1   = 4'd4;
    localparam logic [3:0] ST_DIV1W  = 4'd5;
    localparam logic [3:0] ST_DIV2   = 4'd6;
    localparam logic [3:0] ST_DIV2W  = 4'd7;
    localparam logic [3:0] ST_PT     = 4'd8;
    localparam logic [3:0] ST_DRAIN2 = 4'd9;
    localparam logic [3:0] ST_DIST   = 4'd10;
    localparam logic [3:0] ST_DRAIN3 = 4'd11;
    localparam logic [3:0] ST_UPD    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] outer_reg, outer_next;
    logic [2:0] inner_reg, inner_next;
    logic [1:0] part;
    logic       prt;

    always_comb begin
        state_next = state_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        ctl        = '0;
        part       = inner_reg[1:0];
        prt        = inner_reg[2];
        case (state_reg)
            ST_IDLE: begin
                ctl.in_ready = 1'b1;
                outer_next   = '0;
                inner_next   = '0;
                if (s_fire) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                ctl.op.valid = 1'b1;
                ctl.op.a.src = outer_reg[0] ? SRC_AC : SRC_AB;
                ctl.op.a.idx = inner_reg;
                case (outer_reg[2:1])
                    2'd0:    ctl.op.b.src = SRC_AP;
                    2'd1:    ctl.op.b.src = SRC_BP;
                    default: ctl.op.b.src = SRC_CP;
                endcase
                ctl.op.b.idx = inner_reg;
                ctl.op.shift = SH_0;
                ctl.op.first = (inner_reg == 3'd0);
                ctl.op.dest  = (inner_reg == 3'd2) ? 4'(DST_D0 + outer_reg) : DST_NONE;
                if (inner_reg == 3'd2) begin
                    inner_next = '0;
                    outer_next = outer_reg + 3'd1;
                    if (outer_reg == 3'd5) begin
                        outer_next = '0;
                        state_next = ST_CROSS;
                    end
                end else begin
                    inner_next = inner_reg + 3'd1;
                end
            end
            ST_CROSS: begin
                ctl.op.valid = 1'b1;
                ctl.op.a.src = part[1] ? SRC_DHI : SRC_DLO;
                ctl.op.a.idx = cross_idx(outer_reg[1:0], prt, 1'b0);
                ctl.op.b.src = part[0] ? SRC_DHI : SRC_DLO;
                ctl.op.b.idx = cross_idx(outer_reg[1:0], prt, 1'b1);
                case (part)
                    2'd0:    ctl.op.shift = SH_0;
                    2'd3:    ctl.op.shift = SH_52;
                    default: ctl.op.shift = SH_26;
                endcase
                ctl.op.neg   = prt;
                ctl.op.first = (inner_reg == 3'd0);
                if (inner_reg == 3'd7) begin
                    case (outer_reg[1:0])
                        2'd0:    ctl.op.dest = DST_VC;
                        2'd1:    ctl.op.dest = DST_VB;
                        default: ctl.op.dest = DST_VA;
                    endcase
                    inner_next = '0;
                    outer_next = outer_reg + 3'd1;
                    if (outer_reg == 3'd2) begin
                        outer_next = '0;
                        state_next = ST_DRAIN1;
                    end
                end else begin
                    inner_next = inner_reg + 3'd1;
                end
            end
            ST_DRAIN1, ST_DRAIN2, ST_DRAIN3: begin
                inner_next = inner_reg + 3'd1;
                if (inner_reg == 3'd2) begin
                    inner_next = '0;
                    case (state_reg)
                        ST_DRAIN1: state_next = ST_DIV1;
                        ST_DRAIN2: state_next = ST_DIST;
                        default:   state_next = ST_UPD;
                    endcase
                end
            end
            ST_DIV1: begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIV1W;
            end
            ST_DIV1W: begin
                if (div_done) begin
                    ctl.cap_q1 = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                ctl.div_sel   = 1'b1;
                ctl.div_start = 1'b1;
                state_next    = ST_DIV2W;
            end
            ST_DIV2W: begin
                ctl.div_sel = 1'b1;
                if (div_done) begin
                    ctl.cap_q2 = 1'b1;
                    state_next = ST_PT;
                end
            end
            ST_PT: begin
                ctl.op.valid = 1'b1;
                ctl.op.a.src = inner_reg[0] ? SRC_AC : SRC_DIR;
                ctl.op.a.idx = outer_reg;
                ctl.op.b.src = inner_reg[0] ? SRC_Q2 : SRC_Q1;
                ctl.op.shift = SH_0;
                ctl.op.first = !inner_reg[0];
                ctl.op.dest  = inner_reg[0] ? 4'(DST_PT0 + outer_reg) : DST_NONE;
                if (inner_reg[0]) begin
                    inner_next = '0;
                    outer_next = outer_reg + 3'd1;
                    if (outer_reg == 3'd2) begin
                        outer_next = '0;
                        state_next = ST_DRAIN2;
                    end
                end else begin
                    inner_next = inner_reg + 3'd1;
                end
            end
            ST_DIST: begin
                ctl.op.valid = 1'b1;
                ctl.op.a.src = SRC_DIFF;
                ctl.op.a.idx = inner_reg;
                ctl.op.b.src = SRC_DIFF;
                ctl.op.b.idx = inner_reg;
                ctl.op.shift = SH_0;
                ctl.op.first = (inner_reg == 3'd0);
                ctl.op.dest  = (inner_reg == 3'd2) ? DST_DIST : DST_NONE;
                inner_next   = inner_reg + 3'd1;
                if (inner_reg == 3'd2) begin
                    inner_next = '0;
                    state_next = ST_DRAIN3;
                end
            end
            ST_UPD: begin
                if (!(last && out_full)) begin
                    ctl.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            outer_reg <= '0;
            inner_reg <= '0;
        end else begin
            state_reg <= state_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nearest_point_on_triangle_stream.sv
// top level: nearest point on a stream of triangles to a configured query point
// depends on npt_pkg, npt_mac, npt_div, npt_seq
`default_nettype none

// Each triangle transaction is measured against the query point with the
// Voronoi-region closest-point test and the running best (point, squared
// distance, face) is kept; on the transaction with tlast set the best is sent
// on the m_ side and cleared. All products run through one shared 27x27
// multiply-accumulate unit (18 dot-product steps, 24 partial products for the
// three cross terms, 6 for the point, 3 for the distance) and the ratios through
// a serial divider that yields one quotient bit per cycle. s_tready is low while
// a triangle is measured. A finished result sits in the output register and does
// not hold up the next triangle unless that one is also the last of a search.

module nearest_point_on_triangle_stream
    import npt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_index, zero pad
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // near_x, near_y, near_z, squared_distance, best_face
    output logic [OUT_W-1:0]          m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_wdata
);

    ctl_t ctl;

    logic signed [COORD_W-1:0] query_reg [3];
    logic signed [COORD_W-1:0] a_reg [3];
    logic signed [COORD_W-1:0] b_reg [3];
    logic signed [COORD_W-1:0] c_reg [3];
    logic [FACE_W-1:0]         face_reg;
    logic                      last_reg;

    logic signed [VEC_W-1:0] ab [3];
    logic signed [VEC_W-1:0] ac [3];
    logic signed [VEC_W-1:0] bc [3];
    logic signed [VEC_W-1:0] ap [3];
    logic signed [VEC_W-1:0] bp [3];
    logic signed [VEC_W-1:0] cp [3];
    logic signed [VEC_W-1:0] dir [3];
    logic signed [COORD_W-1:0] base [3];
    logic signed [VEC_W-1:0] diff [3];

    logic signed [DOT_W-1:0]  d_reg [6];
    logic signed [WIDE_W-1:0] va_reg, vb_reg, vc_reg;
    logic [Q_W-1:0]           q1_reg, q2_reg;
    logic signed [COORD_W-1:0] pt_reg [3];
    logic [DIST_W-1:0]        dist_reg;

    logic [DIST_W-1:0]         best_dist_reg;
    logic signed [COORD_W-1:0] best_pt_reg [3];
    logic [FACE_W-1:0]         best_face_reg;
    logic                      best_valid_reg;

    logic                      m_valid_reg;
    logic [COORD_W-1:0]        m_pt_reg [3];
    logic [DIST_W-1:0]         m_dist_reg;
    logic [FACE_W-1:0]         m_face_reg;

    logic signed [OPD_W-1:0]  opa, opb;
    logic signed [WIDE_W-1:0] acc;
    logic                     mac_wr;
    logic [3:0]               mac_dest;

    logic signed [WIDE_W-1:0] div_num, div_den;
    logic [Q_W-1:0]           div_q;
    logic                     div_done;

    logic [2:0]               region;
    logic signed [WIDE_W-1:0] d1, d2, d3, d4, d5, d6, e43, e56, den_in;
    logic signed [WIDE_W-1:0] num1, den1, num2;

    logic [55:0]               rsum;
    logic signed [27:0]        rnd;
    logic signed [27:0]        pt_full;
    logic signed [COORD_W-1:0] pt_sat;
    logic [1:0]                pt_i;
    logic                      take;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    npt_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .div_done (div_done),
        .last     (last_reg),
        .out_full (m_valid_reg && !m_tready),
        .ctl      (ctl)
    );

    npt_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (ctl.op),
        .opa     (opa),
        .opb     (opb),
        .acc     (acc),
        .wr      (mac_wr),
        .wr_dest (mac_dest)
    );

    npt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .num     (div_num),
        .den     (div_den),
        .q       (div_q),
        .done    (div_done)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ab[i] = VEC_W'(b_reg[i]) - VEC_W'(a_reg[i]);
            ac[i] = VEC_W'(c_reg[i]) - VEC_W'(a_reg[i]);
            bc[i] = VEC_W'(c_reg[i]) - VEC_W'(b_reg[i]);
            ap[i] = VEC_W'(query_reg[i]) - VEC_W'(a_reg[i]);
            bp[i] = VEC_W'(query_reg[i]) - VEC_W'(b_reg[i]);
            cp[i] = VEC_W'(query_reg[i]) - VEC_W'(c_reg[i]);
            diff[i] = VEC_W'(query_reg[i]) - VEC_W'(pt_reg[i]);
        end
    end

    // region test
    always_comb begin
        d1 = WIDE_W'(d_reg[0]);
        d2 = WIDE_W'(d_reg[1]);
        d3 = WIDE_W'(d_reg[2]);
        d4 = WIDE_W'(d_reg[3]);
        d5 = WIDE_W'(d_reg[4]);
        d6 = WIDE_W'(d_reg[5]);
        e43 = d4 - d3;
        e56 = d5 - d6;
        den_in = va_reg + vb_reg + vc_reg;
        if (d1 <= 0 && d2 <= 0) begin
            region = RG_A;
        end else if (d3 >= 0 && e43 <= 0) begin
            region = RG_B;
        end else if (vc_reg <= 0 && d1 >= 0 && d3 <= 0) begin
            region = RG_AB;
        end else if (d6 >= 0 && e56 <= 0) begin
            region = RG_C;
        end else if (vb_reg <= 0 && d2 >= 0 && d6 <= 0) begin
            region = RG_AC;
        end else if (va_reg <= 0 && e43 >= 0 && e56 >= 0) begin
            region = RG_BC;
        end else begin
            region = RG_IN;
        end
        num1 = '0;
        den1 = '0;
        num2 = '0;
        case (region)
            RG_AB: begin
                num1 = d1;
                den1 = d1 - d3;
            end
            RG_AC: begin
                num1 = d2;
                den1 = d2 - d6;
            end
            RG_BC: begin
                num1 = e43;
                den1 = e43 + e56;
            end
            RG_IN: begin
                num1 = vb_reg;
                den1 = den_in;
                num2 = vc_reg;
            end
            default: begin
                num1 = '0;
            end
        endcase
        div_num = ctl.div_sel ? num2 : num1;
        div_den = ctl.div_sel ? den_in : den1;
        for (int i = 0; i < 3; i++) begin
            case (region)
                RG_AC: dir[i] = ac[i];
                RG_BC: dir[i] = bc[i];
                default: dir[i] = ab[i];
            endcase
            case (region)
                RG_B, RG_BC: base[i] = b_reg[i];
                RG_C:        base[i] = c_reg[i];
                default:     base[i] = a_reg[i];
            endcase
        end
    end

    function automatic logic signed [OPD_W-1:0] pick(input opnd_t o);
        logic signed [OPD_W-1:0] r;
        logic [1:0]              v;
        v = o.idx[1:0];
        case (o.src)
            SRC_AB:   r = OPD_W'(ab[v]);
            SRC_AC:   r = OPD_W'(ac[v]);
            SRC_AP:   r = OPD_W'(ap[v]);
            SRC_BP:   r = OPD_W'(bp[v]);
            SRC_CP:   r = OPD_W'(cp[v]);
            SRC_DLO:  r = {1'b0, d_reg[o.idx][HALF_W-1:0]};
            SRC_DHI:  r = OPD_W'(signed'(d_reg[o.idx][DOT_W-1:HALF_W]));
            SRC_DIR:  r = OPD_W'(dir[v]);
            SRC_Q1:   r = {2'b00, q1_reg};
            SRC_Q2:   r = {2'b00, q2_reg};
            SRC_DIFF: r = OPD_W'(diff[v]);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign opa = pick(ctl.op.a);
    assign opb = pick(ctl.op.b);

    // point coordinate: base + floor((t + 2^23) / 2^24), saturated
    always_comb begin
        pt_i = 2'(mac_dest - DST_PT0);
        rsum = acc[55:0] + (56'd1 << (RATIO_W - 1));
        rnd = signed'(rsum[RATIO_W+27:RATIO_W]);
        pt_full = 28'(base[pt_i]) + rnd;
        if (pt_full > 28'sd8388607) begin
            pt_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (pt_full < -28'sd8388608) begin
            pt_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            pt_sat = pt_full[COORD_W-1:0];
        end
        take = !best_valid_reg || (dist_reg < best_dist_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
                b_reg[i] <= s_tdata[(3+i)*COORD_W +: COORD_W];
                c_reg[i] <= s_tdata[(6+i)*COORD_W +: COORD_W];
            end
            face_reg <= s_tdata[9*COORD_W +: FACE_W];
            last_reg <= s_tlast;
        end
        if (mac_wr) begin
            case (mac_dest)
                DST_D0:   d_reg[0] <= acc[DOT_W-1:0];
                DST_D1:   d_reg[1] <= acc[DOT_W-1:0];
                DST_D2:   d_reg[2] <= acc[DOT_W-1:0];
                DST_D3:   d_reg[3] <= acc[DOT_W-1:0];
                DST_D4:   d_reg[4] <= acc[DOT_W-1:0];
                DST_D5:   d_reg[5] <= acc[DOT_W-1:0];
                DST_VA:   va_reg <= acc;
                DST_VB:   vb_reg <= acc;
                DST_VC:   vc_reg <= acc;
                DST_PT0, DST_PT1, DST_PT2: pt_reg[pt_i] <= pt_sat;
                DST_DIST: dist_reg <= acc[DIST_W-1:0];
                default:  ;
            endcase
        end
        if (ctl.cap_q1) begin
            q1_reg <= div_q;
        end
        if (ctl.cap_q2) begin
            q2_reg <= div_q;
        end
        if (ctl.upd && last_reg) begin
            for (int i = 0; i < 3; i++) begin
                m_pt_reg[i] <= take ? pt_reg[i] : best_pt_reg[i];
            end
            m_dist_reg <= take ? dist_reg : best_dist_reg;
            m_face_reg <= take ? face_reg : best_face_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                query_reg[i]   <= '0;
                best_pt_reg[i] <= '0;
            end
            best_dist_reg  <= '1;
            best_face_reg  <= '0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_QUERY_X: query_reg[0] <= cfg_wdata;
                    REG_QUERY_Y: query_reg[1] <= cfg_wdata;
                    REG_QUERY_Z: query_reg[2] <= cfg_wdata;
                    default:     ;
                endcase
            end
            if (m_valid_reg && m_tready && !(ctl.upd && last_reg)) begin
                m_valid_reg <= 1'b0;
            end
            if (ctl.upd) begin
                if (last_reg) begin
                    m_valid_reg    <= 1'b1;
                    best_dist_reg  <= '1;
                    best_face_reg  <= '0;
                    best_valid_reg <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        best_pt_reg[i] <= '0;
                    end
                end else if (take) begin
                    best_dist_reg  <= dist_reg;
                    best_face_reg  <= face_reg;
                    best_valid_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        best_pt_reg[i] <= pt_reg[i];
                    end
                end
            end
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_face_reg, m_dist_reg, m_pt_reg[2], m_pt_reg[1], m_pt_reg[0]};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("accepted a transaction while measuring");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> last_reg)
        else $error("result sent for a triangle not marked last");

    a_best_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.upd && !last_reg |=> best_valid_reg)
        else $error("running best not set after a measured triangle");

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for nearest_point_on_triangle_stream: triangle transactions
// in bursts, results drained under stalls, checked against an in-bench predictor or given expectations
// depends on npt_pkg and the rtl of nearest_point_on_triangle_stream
`timescale 1ns / 1ps

module testbench;
    import npt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;
    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 150;

    typedef logic signed [191:0] wide_t;
    typedef longint vec_t [3];

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [DIST_W-1:0]  sq_dist;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } near_t;

    typedef struct {
        longint v[9];
        logic [FACE_W-1:0] face;
        logic last;
    } tri_t;

    typedef struct {
        tri_t t;
        bit typed;
        near_t res;
        bit set_q;
        longint q[3];
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_wdata = '0;
    logic s_tready, m_tvalid;
    logic [OUT_W-1:0] m_tdata;

    // expectation attached to the triangle currently offered
    bit row_typed = 1'b0;
    near_t row_res = '0;

    longint qx = 0, qy = 0, qz = 0;
    logic [DIST_W-1:0] run_dist = DIST_INF;
    vec_t run_pt = '{0, 0, 0};
    logic [FACE_W-1:0] run_face = '0;
    bit run_valid = 1'b0;

    near_t nearest_q[$];
    row_t rows[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;
    int rx_mode = 0;

    nearest_point_on_triangle_stream u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("** nearest_point_on_triangle_stream: FAILED **");
            $finish;
        end
    end

    function automatic longint sat_coord(longint x);
        return x > CMAX ? CMAX : (x < CMIN ? CMIN : x);
    endfunction

    function automatic longint round_q24(longint x);
        return (x + (longint'(1) << 23)) >>> 24;
    endfunction

    function automatic wide_t dot3(vec_t x, vec_t y);
        return wide_t'(x[0]) * wide_t'(y[0]) + wide_t'(x[1]) * wide_t'(y[1])
             + wide_t'(x[2]) * wide_t'(y[2]);
    endfunction

    function automatic longint edge_ratio(wide_t num, wide_t den);
        wide_t n;
        longint q;
        n = num;
        q = 0;
        if (den <= 0 || n <= 0) return 0;
        if (n - den >= 0) return longint'(1) << RATIO_W;
        for (int i = 0; i < RATIO_W; i++) begin
            n = n <<< 1;
            q = q << 1;
            if (n - den >= 0) begin
                n = n - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic void step_along(vec_t base, vec_t dir, longint q, output vec_t pt);
        for (int i = 0; i < 3; i++) pt[i] = sat_coord(base[i] + round_q24(dir[i] * q));
    endfunction

    function automatic logic [DIST_W-1:0] closest_on_triangle(vec_t p, vec_t a, vec_t b,
                                                             vec_t c, output vec_t pt);
        vec_t ab, ac, bc, ap, bp, cp;
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den;
        longint v, w, dd;
        logic [63:0] m, sum;
        for (int i = 0; i < 3; i++) begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab, ap); d2 = dot3(ac, ap);
        d3 = dot3(ab, bp); d4 = dot3(ac, bp);
        d5 = dot3(ab, cp); d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        if (d1 <= 0 && d2 <= 0) pt = a;
        else if (d3 >= 0 && d4 - d3 <= 0) pt = b;
        else if (vc <= 0 && d1 >= 0 && d3 <= 0) step_along(a, ab, edge_ratio(d1, d1 - d3), pt);
        else if (d6 >= 0 && d5 - d6 <= 0) pt = c;
        else if (vb <= 0 && d2 >= 0 && d6 <= 0) step_along(a, ac, edge_ratio(d2, d2 - d6), pt);
        else begin
            e43 = d4 - d3;
            e56 = d5 - d6;
            if (va <= 0 && e43 >= 0 && e56 >= 0) begin
                step_along(b, bc, edge_ratio(e43, e43 + e56), pt);
            end else begin
                den = va + vb + vc;
                v = edge_ratio(vb, den);
                w = edge_ratio(vc, den);
                for (int i = 0; i < 3; i++)
                    pt[i] = sat_coord(a[i] + round_q24(ab[i] * v + ac[i] * w));
            end
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            dd = p[i] - pt[i];
            m = dd < 0 ? -dd : dd;
            if (m >= (64'd1 << 26)) return DIST_INF;
            sum = sum + m * m;
        end
        return sum > DIST_INF ? DIST_INF : sum[DIST_W-1:0];
    endfunction

    // fold one accepted triangle into the running best
    task automatic fold_triangle(logic [IN_W-1:0] d, logic last, bit typed, near_t res);
        vec_t p, a, b, c, pt;
        logic [DIST_W-1:0] sq;
        near_t pred;
        p = '{qx, qy, qz};
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(d[COORD_W*i +: COORD_W]));
            b[i] = longint'($signed(d[COORD_W*(3+i) +: COORD_W]));
            c[i] = longint'($signed(d[COORD_W*(6+i) +: COORD_W]));
        end
        sq = closest_on_triangle(p, a, b, c, pt);
        if (!run_valid || sq < run_dist) begin
            run_dist = sq;
            run_pt = pt;
            run_face = d[9*COORD_W +: FACE_W];
            run_valid = 1'b1;
        end
        if (last) begin
            pred = '{face: run_face, sq_dist: run_dist, z: run_pt[2][COORD_W-1:0],
                     y: run_pt[1][COORD_W-1:0], x: run_pt[0][COORD_W-1:0]};
            nearest_q.push_back(typed ? res : pred);
            run_dist = DIST_INF;
            run_pt = '{0, 0, 0};
            run_face = '0;
            run_valid = 1'b0;
        end
    endtask

    task automatic check_near(near_t got);
        near_t want;
        if (nearest_q.size() == 0) begin
            $error("result transaction with no expectation: %h", got);
            mismatches++;
            return;
        end
        want = nearest_q.pop_front();
        if (got.x !== want.x) begin
            $error("near_x expected %0d got %0d", $signed(want.x), $signed(got.x));
            mismatches++;
        end
        if (got.y !== want.y) begin
            $error("near_y expected %0d got %0d", $signed(want.y), $signed(got.y));
            mismatches++;
        end
        if (got.z !== want.z) begin
            $error("near_z expected %0d got %0d", $signed(want.z), $signed(got.z));
            mismatches++;
        end
        if (got.sq_dist !== want.sq_dist) begin
            $error("squared_distance expected %0d got %0d", want.sq_dist, got.sq_dist);
            mismatches++;
        end
        if (got.face !== want.face) begin
            $error("best_face expected %0d got %0d", want.face, got.face);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) fold_triangle(s_tdata, s_tlast, row_typed, row_res);
            if (m_tvalid && m_tready) check_near(near_t'(m_tdata));
        end
    end

    // receiver: long hold-off on request, else a stall pattern that changes mode
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 4000;
        end
        if (cycles % 97 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 19) == 0);
            endcase
        end
    end

    task automatic send_tri(tri_t t, bit typed, near_t res);
        logic [IN_W-1:0] d;
        int gap;
        d = '0;
        for (int i = 0; i < 9; i++) d[COORD_W*i +: COORD_W] = t.v[i][COORD_W-1:0];
        d[9*COORD_W +: FACE_W] = t.face;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= t.last;
        row_typed <= typed;
        row_res <= res;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (nearest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_query(longint x, longint y, longint z);
        cfg_we <= 1'b1;
        cfg_index <= REG_QUERY_X;
        cfg_wdata <= x[COORD_W-1:0];
        @(posedge aclk);
        qx = x;
        cfg_index <= REG_QUERY_Y;
        cfg_wdata <= y[COORD_W-1:0];
        @(posedge aclk);
        qy = y;
        cfg_index <= REG_QUERY_Z;
        cfg_wdata <= z[COORD_W-1:0];
        @(posedge aclk);
        qz = z;
        // spare index, must leave the query untouched
        cfg_index <= REG_SPARE;
        cfg_wdata <= COORD_W'($urandom());
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic add_row(longint ax, longint ay, longint az, longint bx, longint by,
                           longint bz, longint cx, longint cy, longint cz,
                           logic [FACE_W-1:0] face, logic last, bit typed, near_t res);
        row_t r;
        r.t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        r.t.face = face;
        r.t.last = last;
        r.typed = typed;
        r.res = res;
        r.set_q = 1'b0;
        r.q = '{0, 0, 0};
        rows.push_back(r);
    endtask

    task automatic mark_query(longint x, longint y, longint z);
        rows[rows.size()-1].set_q = 1'b1;
        rows[rows.size()-1].q = '{x, y, z};
    endtask

    function automatic longint near_coord(longint centre, longint span);
        return sat_coord(centre + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic tri_t make_tri();
        tri_t t;
        int mode;
        longint span;
        longint picks[4];
        longint p[3];
        picks = '{CMIN, CMAX, 0, -1};
        p = '{qx, qy, qz};
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 256;
            2: span = 4096;
            default: span = 65536;
        endcase
        for (int i = 0; i < 9; i++) begin
            if (mode == 7) t.v[i] = longint'($signed(24'($urandom())));
            else if (mode == 8) t.v[i] = picks[$urandom_range(0, 3)];
            else t.v[i] = near_coord(p[i % 3], span);
        end
        if (mode == 9) begin
            for (int i = 0; i < 3; i++) begin
                t.v[3+i] = t.v[i];
                if ($urandom_range(0, 1)) t.v[6+i] = t.v[i];
            end
        end
        t.face = FACE_W'($urandom());
        t.last = 1'b0;
        return t;
    endfunction

    initial begin
        near_t none;
        tri_t t;
        int len;
        int sent;
        longint qs[8][3];
        none = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // query at reset value (origin)
        add_row(256, 0, 0, 256, 0, 0, 256, 0, 0, 20'd5, 1, 1,
                '{face: 20'd5, sq_dist: 52'd65536, z: 0, y: 0, x: 24'd256});
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 1, 1,
                '{face: 20'hFFFFF, sq_dist: 0, z: 0, y: 0, x: 0});
        // ties keep the first face
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 20'd7, 0, 0, none);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 20'd9, 1, 1,
                '{face: 20'd7, sq_dist: 0, z: 0, y: 0, x: 0});
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 20'd3, 1, 1,
                '{face: 20'd3, sq_dist: 52'd211106182201347, z: CMAX[23:0], y: CMAX[23:0],
                  x: CMAX[23:0]});
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 20'd1, 0, 0, none);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 20'd2, 1, 1,
                '{face: 20'd2, sq_dist: 0, z: 0, y: 0, x: 0});
        // one triangle per closest feature, and one with two corners equal
        add_row(100, 100, 0, 400, 100, 0, 100, 400, 0, 20'd11, 1, 0, none);
        add_row(-400, 100, 0, -100, 100, 0, -400, 400, 0, 20'd12, 1, 0, none);
        add_row(100, -400, 0, 400, -400, 0, 100, -100, 0, 20'd13, 1, 0, none);
        add_row(-100, 100, 0, 100, 100, 0, 0, 400, 0, 20'd14, 1, 0, none);
        add_row(100, -100, 0, 400, 0, 0, 100, 100, 0, 20'd15, 1, 0, none);
        add_row(-400, 0, 0, -100, -100, 0, -100, 100, 0, 20'd16, 1, 0, none);
        add_row(-100, -100, 5, 100, -100, 5, 0, 100, 5, 20'd17, 1, 0, none);
        add_row(300, 0, 0, 300, 0, 0, 0, 500, 0, 20'd18, 1, 0, none);
        // query at the top corner, triangle at the bottom corner
        add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 20'hFFFFF, 1, 1,
                '{face: 20'hFFFFF, sq_dist: 52'd844424829468675, z: CMIN[23:0],
                  y: CMIN[23:0], x: CMIN[23:0]});
        mark_query(CMAX, CMAX, CMAX);
        add_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, 20'd21, 1, 0, none);
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 20'd22, 1, 1,
                '{face: 20'd22, sq_dist: 0, z: CMAX[23:0], y: CMAX[23:0], x: CMAX[23:0]});
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 20'd23, 1, 1,
                '{face: 20'd23, sq_dist: 52'd844424829468675, z: CMAX[23:0],
                  y: CMAX[23:0], x: CMAX[23:0]});
        mark_query(CMIN, CMIN, CMIN);

        foreach (rows[i]) begin
            if (rows[i].set_q) begin
                drain();
                set_query(rows[i].q[0], rows[i].q[1], rows[i].q[2]);
            end
            send_tri(rows[i].t, rows[i].typed, rows[i].res);
        end
        drain();

        qs = '{'{int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096, 0},
               '{CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN}, '{0, 0, 0},
               '{0, 0, 0}, '{CMAX, CMIN, CMAX}, '{0, 0, 0}, '{CMIN, CMAX, 0}};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 4 || ph == 6) begin
                for (int k = 0; k < 3; k++) qs[ph][k] = longint'($signed(24'($urandom())));
            end
            set_query(qs[ph][0], qs[ph][1], qs[ph][2]);
            if (ph == 2) hold_go = 1'b1;
            sent = 0;
            while (sent < 235) begin
                len = (ph == 2 && sent < 40) ? 1 : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    t = make_tri();
                    t.last = (k == len - 1);
                    send_tri(t, 1'b0, none);
                    sent++;
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** nearest_point_on_triangle_stream: PASSED **");
        end else begin
            $display("** nearest_point_on_triangle_stream: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/npt_pkg.sv
hw/rtl/npt_mac.sv
hw/rtl/npt_div.sv
hw/rtl/npt_seq.sv
hw/rtl/nearest_point_on_triangle_stream.sv
dv/testbench.sv
